// ----- sv/iasc_pkg.sv -----
// Package for the interleaved ADC average scaler: sizes, mode codes, channel constants.
// Used by every module of the block; depends on nothing.

package iasc_pkg;

	localparam int CHANNELS = 4;
	localparam int SAMPLES_PER_CHANNEL = 10;

	localparam int SAMPLE_W = 12;
	localparam int SUM_W = 16;
	localparam int VALUE_W = 30;
	localparam int CHAN_OUT_W = 2;
	localparam int MODE_W = 2;
	localparam int FRAC_W = 16;

	localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int CNT_W = (SAMPLES_PER_CHANNEL > 1) ? $clog2(SAMPLES_PER_CHANNEL) : 1;
	localparam logic [CH_W-1:0] LAST_CH = CH_W'(CHANNELS - 1);
	localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(SAMPLES_PER_CHANNEL - 1);

	// Gains are in units of 1/10000, so every value is sum * gain * 2^16 / DEN before any channel offset.
	localparam longint unsigned DEN = longint'(SAMPLES_PER_CHANNEL) * 10000;
	localparam int GAIN_W = 14;
	localparam int OFF_W = 12;
	localparam int MG_W = 33;
	localparam int RECIP_SHIFT = 32;
	// Remainder width: wide enough for twice the divisor, and above the fraction bits.
	localparam int RW = ($clog2(2 * DEN) > FRAC_W) ? $clog2(2 * DEN) : FRAC_W + 1;
	localparam logic [RW-1:0] DEN_R = RW'(DEN);

	typedef enum logic [MODE_W-1:0] {
		MODE_RAW     = 2'd0,
		MODE_VOLTAGE = 2'd1,
		MODE_REMOTE  = 2'd2
	} mode_t;

	typedef logic [CHANNELS-1:0][SUM_W-1:0] sums_t;

	typedef struct packed {
		logic  valid;
		sums_t sums;
	} frame_t;

	// Scaled reciprocal of DEN for a given gain; only ever evaluated on constants.
	function automatic logic [MG_W-1:0] recip(input longint unsigned gain);
		return MG_W'((gain << RECIP_SHIFT) / DEN);
	endfunction

	localparam logic [GAIN_W-1:0] GAIN_RAW   = GAIN_W'(10000);
	localparam logic [GAIN_W-1:0] GAIN_VOLT  = GAIN_W'(8);
	localparam logic [GAIN_W-1:0] GAIN_YAW   = GAIN_W'(879);
	localparam logic [GAIN_W-1:0] GAIN_THR   = GAIN_W'(2440);
	localparam logic [GAIN_W-1:0] GAIN_PR    = GAIN_W'(146);

	localparam logic [MG_W-1:0] MG_RAW  = recip(10000);
	localparam logic [MG_W-1:0] MG_VOLT = recip(8);
	localparam logic [MG_W-1:0] MG_YAW  = recip(879);
	localparam logic [MG_W-1:0] MG_THR  = recip(2440);
	localparam logic [MG_W-1:0] MG_PR   = recip(146);

	localparam logic signed [OFF_W-1:0] OFF_YAW = -12'sd180;
	localparam logic signed [OFF_W-1:0] OFF_THR = 12'sd1000;
	localparam logic signed [OFF_W-1:0] OFF_PR  = -12'sd30;

endpackage

// ----- sv/interleaved_adc_average_scaler_core.sv -----
// Top level of the interleaved ADC average scaler: mode register, front, queue, back end.
// Depends on iasc_pkg, iasc_front, iasc_fifo and iasc_back.
//
//   Port group   Handshake                     Payload
//   sample       sample_valid / sample_ready   adc_sample[11:0]
//   result       result_valid / result_ready   channel[1:0], value[29:0] signed, last
//   cfg          cfg_valid / cfg_ready         output_mode[1:0]
//
// One sample is taken every cycle while sample_ready is high. A frame's results leave one per cycle
// while result_ready is high, through a four-stage reciprocal divide pipeline.
// A two-frame queue sits between accumulation and scaling, so a stalled result port
// only holds off samples once two finished frames are waiting.
// Reset clears the sums, the counters, the queue and the mode register; cfg_ready stays high.

module interleaved_adc_average_scaler_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                sample_valid,
	output logic                                sample_ready,
	input  logic [iasc_pkg::SAMPLE_W-1:0]       adc_sample,
	output logic                                result_valid,
	input  logic                                result_ready,
	output logic [iasc_pkg::CHAN_OUT_W-1:0]     channel,
	output logic signed [iasc_pkg::VALUE_W-1:0] value,
	output logic                                last,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [iasc_pkg::MODE_W-1:0]         output_mode
);

	logic [iasc_pkg::MODE_W-1:0] mode_q;
	iasc_pkg::frame_t            push;
	iasc_pkg::frame_t            head;
	logic                        queue_full;
	logic                        pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= iasc_pkg::MODE_RAW;
		end else if (cfg_valid && cfg_ready) begin
			mode_q <= output_mode;
		end
	end

	iasc_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.adc_sample   (adc_sample),
		.queue_full   (queue_full),
		.push         (push)
	);

	iasc_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (queue_full),
		.pop    (pop),
		.head   (head)
	);

	iasc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.pop          (pop),
		.mode         (mode_q),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.channel      (channel),
		.value        (value),
		.last         (last)
	);

	a_last_channel: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && last |-> channel == iasc_pkg::CHAN_OUT_W'(iasc_pkg::LAST_CH))
		else $error("last flag on a result that is not the final channel");

	a_ready_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!sample_ready |-> queue_full)
		else $error("samples held off while the frame queue has room");

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		push.valid |-> !queue_full)
		else $error("frame pushed into a full queue");

	a_pop_needs_frame: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head.valid)
		else $error("frame popped from an empty queue");

endmodule

// ----- sv/iasc_front.sv -----
// Front end of the ADC average scaler: accumulates per-channel sums and hands off frames.
// Depends on iasc_pkg.

module iasc_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            sample_valid,
	output logic                            sample_ready,
	input  logic [iasc_pkg::SAMPLE_W-1:0]   adc_sample,
	input  logic                            queue_full,
	output iasc_pkg::frame_t                push
);

	iasc_pkg::sums_t              sums_q;
	logic [iasc_pkg::CH_W-1:0]    ch_q;
	logic [iasc_pkg::CNT_W-1:0]   cnt_q;
	logic [iasc_pkg::SUM_W-1:0]   cur_sum;
	logic                         accept;
	logic                         frame_end;

	assign sample_ready = !queue_full;
	assign accept = sample_valid && sample_ready;

	always_comb begin
		cur_sum = sums_q[ch_q] + iasc_pkg::SUM_W'(adc_sample);
		frame_end = (ch_q == iasc_pkg::LAST_CH) && (cnt_q == iasc_pkg::LAST_CNT);
		push.valid = accept && frame_end;
		for (int i = 0; i < iasc_pkg::CHANNELS; i++) begin
			push.sums[i] = (iasc_pkg::CH_W'(i) == ch_q) ? cur_sum : sums_q[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sums_q <= '0;
			ch_q <= '0;
			cnt_q <= '0;
		end else if (accept) begin
			if (frame_end) begin
				sums_q <= '0;
			end else begin
				sums_q[ch_q] <= cur_sum;
			end
			if (ch_q == iasc_pkg::LAST_CH) begin
				ch_q <= '0;
				cnt_q <= (cnt_q == iasc_pkg::LAST_CNT) ? '0 : cnt_q + 1'b1;
			end else begin
				ch_q <= ch_q + 1'b1;
			end
		end
	end

endmodule

// ----- sv/iasc_fifo.sv -----
// Two-entry frame queue between the accumulating front and the scaling back end.
// Depends on iasc_pkg.

module iasc_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  iasc_pkg::frame_t  push,
	output logic              full,
	input  logic              pop,
	output iasc_pkg::frame_t  head
);

	iasc_pkg::sums_t mem_q [2];
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      count_q;

	assign full = (count_q == 2'd2);
	assign head.valid = (count_q != 2'd0);
	assign head.sums = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push.valid) begin
			mem_q[wr_ptr_q] <= push.sums;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= '0;
		end else begin
			if (push.valid) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push.valid, pop})
				2'b10: count_q <= count_q + 2'd1;
				2'b01: count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- sv/iasc_back.sv -----
// Back end of the ADC average scaler: walks the channels of a queued frame through a
// four-stage divide-and-scale pipeline. Depends on iasc_pkg.

module iasc_back (
	input  logic                               clk,
	input  logic                               arst_n,
	input  iasc_pkg::frame_t                   head,
	output logic                               pop,
	input  logic [iasc_pkg::MODE_W-1:0]        mode,
	output logic                               result_valid,
	input  logic                               result_ready,
	output logic [iasc_pkg::CHAN_OUT_W-1:0]    channel,
	output logic signed [iasc_pkg::VALUE_W-1:0] value,
	output logic                               last
);

	logic                                adv;
	logic                                issue;
	logic [iasc_pkg::CH_W-1:0]           seq_ch_q;
	logic [1:0]                          rk;
	logic [iasc_pkg::GAIN_W-1:0]         gain;
	logic [iasc_pkg::MG_W-1:0]           mg;
	logic signed [iasc_pkg::OFF_W-1:0]   off;

	logic                                v_s1, v_s2, v_s3;
	logic [iasc_pkg::CH_W-1:0]           ch_s1, ch_s2, ch_s3;
	logic [iasc_pkg::SUM_W-1:0]          sum_s1;
	logic [iasc_pkg::GAIN_W-1:0]         gain_s1;
	logic [iasc_pkg::MG_W-1:0]           mg_s1;
	logic signed [iasc_pkg::OFF_W-1:0]   off_s1, off_s2, off_s3;

	logic [iasc_pkg::SUM_W+iasc_pkg::MG_W-1:0]     est_prod;
	logic [iasc_pkg::SUM_W+iasc_pkg::GAIN_W-1:0]   sg_prod;
	logic [iasc_pkg::MG_W-1:0]                     q0_s2, q0_s3;
	logic [iasc_pkg::RW-1:0]                       sgl_s2;
	logic [iasc_pkg::RW-1:0]                       rem;
	logic                                          inc_s3;
	logic signed [iasc_pkg::VALUE_W-1:0]           off_ext;

	assign adv = !result_valid || result_ready;
	assign issue = adv && head.valid;
	assign pop = issue && (seq_ch_q == iasc_pkg::LAST_CH);

	// Channel constants. Channels past the fourth reuse the pitch/roll scaling.
	always_comb begin
		rk = (32'(seq_ch_q) < 32'd4) ? 2'(seq_ch_q) : 2'd3;
		gain = iasc_pkg::GAIN_RAW;
		mg = iasc_pkg::MG_RAW;
		off = '0;
		case (mode)
			iasc_pkg::MODE_VOLTAGE: begin
				gain = iasc_pkg::GAIN_VOLT;
				mg = iasc_pkg::MG_VOLT;
			end
			iasc_pkg::MODE_REMOTE: begin
				case (rk)
					2'd0: begin
						gain = iasc_pkg::GAIN_YAW;
						mg = iasc_pkg::MG_YAW;
						off = iasc_pkg::OFF_YAW;
					end
					2'd1: begin
						gain = iasc_pkg::GAIN_THR;
						mg = iasc_pkg::MG_THR;
						off = iasc_pkg::OFF_THR;
					end
					default: begin
						gain = iasc_pkg::GAIN_PR;
						mg = iasc_pkg::MG_PR;
						off = iasc_pkg::OFF_PR;
					end
				endcase
			end
			default: begin
				gain = iasc_pkg::GAIN_RAW;
				mg = iasc_pkg::MG_RAW;
			end
		endcase
	end

	// The reciprocal estimate is at most one below the true quotient. The remainder is
	// below twice the divisor, so its low RW bits decide the correction.
	always_comb begin
		est_prod = (iasc_pkg::SUM_W+iasc_pkg::MG_W)'(sum_s1) *
			(iasc_pkg::SUM_W+iasc_pkg::MG_W)'(mg_s1);
		sg_prod = (iasc_pkg::SUM_W+iasc_pkg::GAIN_W)'(sum_s1) *
			(iasc_pkg::SUM_W+iasc_pkg::GAIN_W)'(gain_s1);
		rem = sgl_s2 - q0_s2[iasc_pkg::RW-1:0] * iasc_pkg::DEN_R;
		off_ext = iasc_pkg::VALUE_W'(off_s3) <<< iasc_pkg::FRAC_W;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ch_s1 <= seq_ch_q;
			sum_s1 <= head.sums[seq_ch_q];
			gain_s1 <= gain;
			mg_s1 <= mg;
			off_s1 <= off;

			ch_s2 <= ch_s1;
			q0_s2 <= est_prod[iasc_pkg::SUM_W+iasc_pkg::MG_W-1:iasc_pkg::FRAC_W];
			sgl_s2 <= {sg_prod[iasc_pkg::RW-iasc_pkg::FRAC_W-1:0], {iasc_pkg::FRAC_W{1'b0}}};
			off_s2 <= off_s1;

			ch_s3 <= ch_s2;
			q0_s3 <= q0_s2;
			inc_s3 <= (rem >= iasc_pkg::DEN_R);
			off_s3 <= off_s2;

			channel <= iasc_pkg::CHAN_OUT_W'(ch_s3);
			last <= (ch_s3 == iasc_pkg::LAST_CH);
			value <= q0_s3[iasc_pkg::VALUE_W-1:0] + iasc_pkg::VALUE_W'(inc_s3) + off_ext;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_ch_q <= '0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			if (issue) begin
				seq_ch_q <= (seq_ch_q == iasc_pkg::LAST_CH) ? '0 : seq_ch_q + 1'b1;
			end
			if (adv) begin
				v_s1 <= issue;
				v_s2 <= v_s1;
				v_s3 <= v_s2;
				result_valid <= v_s3;
			end
		end
	end

endmodule

// ----- sim/iasc_average_check.sv -----
// Watches the sample, config and result channels of the interleaved ADC average scaler.
// It predicts each frame's scaled channel averages and compares them with the results.
// Depends on iasc_pkg.

module iasc_average_check (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                sample_valid,
	input  logic                                sample_ready,
	input  logic [iasc_pkg::SAMPLE_W-1:0]       adc_sample,
	input  logic                                result_valid,
	input  logic                                result_ready,
	input  logic [iasc_pkg::CHAN_OUT_W-1:0]     channel,
	input  logic signed [iasc_pkg::VALUE_W-1:0] value,
	input  logic                                last,
	input  logic                                cfg_valid,
	input  logic                                cfg_ready,
	input  logic [iasc_pkg::MODE_W-1:0]         output_mode,
	output int                                  outstanding,
	output int                                  failures
);

	import iasc_pkg::*;

	localparam int CH_YAW      = 0;
	localparam int CH_THROTTLE = 1;

	localparam longint unsigned FRAC_SCALE = 64'd65536;
	localparam longint unsigned GAIN_DEN   = SAMPLES_PER_CHANNEL * 10000;

	typedef struct packed {
		logic [CHAN_OUT_W-1:0]     chan;
		logic signed [VALUE_W-1:0] val;
		logic                      fin;
	} channel_result_t;

	channel_result_t awaited_results[$];
	channel_result_t head;
	logic [MODE_W-1:0] active_mode;
	logic [SUM_W-1:0]  sums [CHANNELS];
	int                lane;
	int                rounds;
	int                fail_count = 0;
	int                c;

	assign failures = fail_count;

	// Average of one channel scaled as the mode selects, floored, with 16 fraction bits.
	function automatic logic signed [VALUE_W-1:0] scaled_average(input int ch,
			input logic [SUM_W-1:0] sum, input logic [MODE_W-1:0] mode);
		longint unsigned total;
		longint unsigned gain;
		longint          offset;
		longint          scaled;
		total = sum;
		case (mode)
			MODE_VOLTAGE: begin
				scaled = longint'((total * 64'd8 * FRAC_SCALE) / GAIN_DEN);
			end
			MODE_REMOTE: begin
				if (ch == CH_YAW) begin
					gain = 879;
					offset = -180;
				end else if (ch == CH_THROTTLE) begin
					gain = 2440;
					offset = 1000;
				end else begin
					gain = 146;
					offset = -30;
				end
				scaled = longint'((total * gain * FRAC_SCALE) / GAIN_DEN);
				scaled = scaled + offset * longint'(FRAC_SCALE);
			end
			default: begin
				// The unused mode code falls back to the plain average.
				scaled = longint'((total * FRAC_SCALE) / longint'(SAMPLES_PER_CHANNEL));
			end
		endcase
		return scaled[VALUE_W-1:0];
	endfunction

	task automatic note_mismatch(input string what, input longint got, input longint want);
		$display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_mode = MODE_RAW;
			lane = 0;
			rounds = 0;
			for (c = 0; c < CHANNELS; c++) sums[c] = '0;
			awaited_results.delete();
			outstanding <= 0;
		end else begin
			if (cfg_valid && cfg_ready)
				active_mode = output_mode;

			if (result_valid && result_ready) begin
				if (awaited_results.size() == 0) begin
					note_mismatch("result with none awaited, value", value, 0);
				end else begin
					head = awaited_results.pop_front();
					if (channel !== head.chan)
						note_mismatch("channel", channel, head.chan);
					if (value !== head.val)
						note_mismatch("value", value, head.val);
					if (last !== head.fin)
						note_mismatch("last", last, head.fin);
				end
			end

			if (sample_valid && sample_ready) begin
				sums[lane] = sums[lane] + SUM_W'(adc_sample);
				lane++;
				if (lane == CHANNELS) begin
					lane = 0;
					rounds++;
					if (rounds == SAMPLES_PER_CHANNEL) begin
						rounds = 0;
						for (c = 0; c < CHANNELS; c++) begin
							head.chan = CHAN_OUT_W'(c);
							head.val = scaled_average(c, sums[c], active_mode);
							head.fin = (c == CHANNELS - 1);
							awaited_results.push_back(head);
							sums[c] = '0;
						end
					end
				end
			end

			outstanding <= awaited_results.size();
		end
	end

endmodule

// ----- sim/interleaved_adc_average_scaler_core_test.sv -----
// Testbench top for the interleaved ADC average scaler: clock, reset, stimulus, verdict.
// Depends on iasc_pkg, the core and iasc_average_check.

module interleaved_adc_average_scaler_core_test;

	import iasc_pkg::*;

	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
	localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = '1;

	localparam int FRAME_ZERO      = 0;
	localparam int FRAME_FULL      = 1;
	localparam int FRAME_NEAR_EDGE = 2;
	localparam int FRAME_LEVELS    = 3;
	localparam int FRAME_UNIFORM   = 4;

	localparam int READY_ALWAYS = 0;
	localparam int READY_COIN   = 1;
	localparam int READY_RARE   = 2;
	localparam int READY_MOSTLY = 3;

	localparam int SETTLE_CYCLES = 8;
	localparam int DRAIN_CYCLES  = 16;
	localparam int CYCLE_LIMIT   = 200000;

	logic                        clk;
	logic                        arst_n;
	logic                        sample_valid;
	logic                        sample_ready;
	logic [SAMPLE_W-1:0]         adc_sample;
	logic                        result_valid;
	logic                        result_ready = 1'b0;
	logic [CHAN_OUT_W-1:0]       channel;
	logic signed [VALUE_W-1:0]   value;
	logic                        last;
	logic                        cfg_valid;
	logic                        cfg_ready;
	logic [MODE_W-1:0]           output_mode;

	int outstanding;
	int failures;
	int burst_left = 0;
	int stall_style = READY_ALWAYS;
	int stall_window = 0;
	int cycle_count = 0;

	interleaved_adc_average_scaler_core u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.adc_sample   (adc_sample),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.channel      (channel),
		.value        (value),
		.last         (last),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.output_mode  (output_mode)
	);

	iasc_average_check u_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.adc_sample   (adc_sample),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.channel      (channel),
		.value        (value),
		.last         (last),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.output_mode  (output_mode),
		.outstanding  (outstanding),
		.failures     (failures)
	);

	always #1 clk = ~clk;

	// The result side switches between stall styles over windows of random length.
	always @(posedge clk) begin
		if (stall_window == 0) begin
			stall_style <= $urandom_range(READY_ALWAYS, READY_MOSTLY);
			stall_window <= $urandom_range(16, 96);
		end else begin
			stall_window <= stall_window - 1;
		end
		case (stall_style)
			READY_ALWAYS: result_ready <= 1'b1;
			READY_COIN:   result_ready <= 1'($urandom_range(0, 1));
			READY_RARE:   result_ready <= ($urandom_range(0, 5) == 0);
			default:      result_ready <= ($urandom_range(0, 7) != 0);
		endcase
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// Called and returning at a rising edge; the item is accepted at the edge it returns on.
	task automatic push_sample(input logic [SAMPLE_W-1:0] s);
		if (burst_left == 0) begin
			sample_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 12);
		end
		sample_valid <= 1'b1;
		adc_sample <= s;
		@(negedge clk);
		while (!sample_ready) @(negedge clk);
		@(posedge clk);
		burst_left--;
	endtask

	task automatic send_frame(input int style);
		int i;
		int level [CHANNELS];
		int s;
		for (i = 0; i < CHANNELS; i++) level[i] = $urandom_range(0, 4095);
		for (i = 0; i < CHANNELS * SAMPLES_PER_CHANNEL; i++) begin
			case (style)
				FRAME_ZERO: s = 0;
				FRAME_FULL: s = SAMPLE_MAX;
				FRAME_NEAR_EDGE: s = $urandom_range(0, 1) ? 4095 - $urandom_range(0, 15)
					: $urandom_range(0, 15);
				FRAME_LEVELS: begin
					s = level[i % CHANNELS] + $urandom_range(0, 64) - 32;
					if (s < 0) s = 0;
					if (s > 4095) s = 4095;
				end
				default: s = $urandom_range(0, 4095);
			endcase
			push_sample(SAMPLE_W'(s));
		end
	endtask

	// Holds off samples until every awaited result has left and the pipeline has settled.
	task automatic await_idle(input int settle);
		sample_valid <= 1'b0;
		burst_left = 0;
		@(negedge clk);
		while (outstanding != 0) @(negedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task automatic write_mode(input logic [MODE_W-1:0] m);
		cfg_valid <= 1'b1;
		output_mode <= m;
		@(negedge clk);
		while (!cfg_ready) @(negedge clk);
		@(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		logic [MODE_W-1:0] phase_mode [5];
		int p;
		int f;
		int pick;
		clk = 1'b0;
		arst_n = 1'b0;
		sample_valid = 1'b0;
		adc_sample = '0;
		cfg_valid = 1'b0;
		output_mode = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: full scale in the reset mode, then both extremes under remote scaling,
		// where the negative offsets show up on an all-zero frame.
		send_frame(FRAME_FULL);
		await_idle(SETTLE_CYCLES);
		write_mode(MODE_REMOTE);
		send_frame(FRAME_ZERO);
		send_frame(FRAME_FULL);

		phase_mode[0] = MODE_VOLTAGE;
		phase_mode[1] = MODE_UNUSED;
		phase_mode[2] = MODE_RAW;
		phase_mode[3] = MODE_REMOTE;
		phase_mode[4] = MODE_W'($urandom_range(0, 3));
		for (p = 0; p < 5; p++) begin
			await_idle(SETTLE_CYCLES);
			write_mode(phase_mode[p]);
			for (f = 0; f < ((p < 2) ? 2 : 1); f++) begin
				pick = $urandom_range(0, 9);
				if (pick == 0) send_frame(FRAME_ZERO);
				else if (pick == 1) send_frame(FRAME_FULL);
				else if (pick < 4) send_frame(FRAME_NEAR_EDGE);
				else if (pick < 7) send_frame(FRAME_LEVELS);
				else send_frame(FRAME_UNIFORM);
			end
		end

		await_idle(DRAIN_CYCLES);
		if (failures == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

// ----- interleaved_adc_average_scaler_core.f -----
sv/iasc_pkg.sv
sv/iasc_front.sv
sv/iasc_fifo.sv
sv/iasc_back.sv
sv/interleaved_adc_average_scaler_core.sv
sim/iasc_average_check.sv
sim/interleaved_adc_average_scaler_core_test.sv
